// ===== hw/rtl/scfp_pkg.sv =====
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants for the serial command frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

  localparam int unsigned DIGIT_DEPTH_DEF = 27;

  localparam int unsigned VAL_W    = 10;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned MAG_W    = 9;
  localparam int unsigned PROD_W   = PERIOD_W + MAG_W;
  localparam int unsigned ALU_W    = 12;
  localparam int unsigned LEN_W    = 5;

  // shared multiplier: period * magnitude, then (product >> 2) * reciprocal of 125
  localparam int unsigned MUL_A_W  = PROD_W - 2;
  localparam int unsigned MUL_B_W  = 24;
  localparam int unsigned MUL_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned RECIP_SH = 30;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 1'd1;

  localparam logic [PERIOD_W-1:0] MOTOR_PERIOD_RST  = 16'd1000;
  localparam logic [LIMIT_W-1:0]  TIMEOUT_LIMIT_RST = 8'd10;

  localparam logic [7:0] CHAR_START  = 8'h25;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5a;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] OPC_MOVE    = 8'h6d;

  localparam logic [ALU_W-1:0]   MOVE_BIAS_HI = 12'hffb;  // -5, hundreds digit bias
  localparam logic [MUL_B_W-1:0] RECIP_125    = 24'd8589935;  // ceil(2^30 / 125)

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_LENGTH,
    PS_OPCODE,
    PS_DATA,
    PS_DONE
  } parse_state_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_ACC,
    SQ_ABS,
    SQ_MUL,
    SQ_DIV,
    SQ_DONE
  } seq_state_e;

  typedef struct packed {
    logic       done;
    logic [7:0] opcode;
  } parse_status_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [VAL_W-1:0]    x_move;
    logic [VAL_W-1:0]    y_move;
    logic [VAL_W-1:0]    spin_value;
    logic                reverse;
    logic [PERIOD_W-1:0] width;
  } move_result_t;

  typedef struct packed {
    logic                frame_done;
    logic [7:0]          opcode;
    logic [VAL_W-1:0]    x_move;
    logic [VAL_W-1:0]    y_move;
    logic [VAL_W-1:0]    spin_value;
    logic                motor_update;
    logic                motor_reverse;
    logic [PERIOD_W-1:0] motor_width;
    logic                failsafe_stop;
  } result_t;

endpackage

// ===== hw/rtl/scfp_parser.sv =====
// ----------------------------------------------------------------------------
// scfp_parser
// Frame state machine and digit store; reports frame completion per byte.
// ----------------------------------------------------------------------------
module scfp_parser #(
  parameter int unsigned DIGIT_DEPTH = scfp_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           byte_valid_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic [$clog2(DIGIT_DEPTH)-1:0] rd_idx_i,
  output logic [3:0]                     rd_digit_o,
  output scfp_pkg::parse_status_t        status_o
);

  localparam int unsigned IDX_W = $clog2(DIGIT_DEPTH);
  localparam int unsigned CNT_W = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > scfp_pkg::LEN_W) ? CNT_W : scfp_pkg::LEN_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DIGIT_DEPTH);

  scfp_pkg::parse_state_e state_q, state_d;
  logic [scfp_pkg::LEN_W-1:0] len_q, len_d;
  logic [7:0]                 opc_q, opc_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [3:0]                 store_q [DIGIT_DEPTH];

  logic             is_lower, is_upper, is_digit, is_start;
  logic             wr_en;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       len_full, digit_full;
  scfp_pkg::parse_state_e restart;

  assign is_lower = (rx_byte_i >= scfp_pkg::CHAR_LOW_A) && (rx_byte_i <= scfp_pkg::CHAR_LOW_Z);
  assign is_upper = (rx_byte_i >= scfp_pkg::CHAR_UP_A) && (rx_byte_i <= scfp_pkg::CHAR_UP_Z);
  assign is_digit = (rx_byte_i >= scfp_pkg::CHAR_ZERO) && (rx_byte_i <= scfp_pkg::CHAR_NINE);
  assign is_start = (rx_byte_i == scfp_pkg::CHAR_START);
  assign restart  = is_start ? scfp_pkg::PS_LENGTH : scfp_pkg::PS_IDLE;
  assign cnt_inc  = cnt_q + 1'b1;
  assign len_full   = rx_byte_i - scfp_pkg::CHAR_LOW_A;
  assign digit_full = rx_byte_i - scfp_pkg::CHAR_ZERO;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    opc_d   = opc_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    if (byte_valid_i) begin
      unique case (state_q)
        scfp_pkg::PS_IDLE: begin
          state_d = restart;
        end
        scfp_pkg::PS_LENGTH: begin
          if (is_lower) begin
            len_d   = len_full[scfp_pkg::LEN_W-1:0];
            state_d = scfp_pkg::PS_OPCODE;
          end else begin
            state_d = restart;
          end
        end
        scfp_pkg::PS_OPCODE: begin
          if (is_lower || is_upper) begin
            opc_d   = rx_byte_i;
            cnt_d   = '0;
            state_d = scfp_pkg::PS_DATA;
          end else begin
            state_d = restart;
          end
        end
        scfp_pkg::PS_DATA: begin
          if (is_digit) begin
            wr_en = (cnt_q < DEPTH_CNT);
            cnt_d = cnt_inc;
            if ((CMP_W'(cnt_inc) == CMP_W'(len_q)) || (cnt_inc >= DEPTH_CNT)) begin
              state_d = scfp_pkg::PS_DONE;
            end
          end else begin
            state_d = restart;
          end
        end
        default: begin
          state_d = restart;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scfp_pkg::PS_IDLE;
      len_q   <= '0;
      opc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      opc_q   <= opc_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else if (wr_en) begin
      store_q[cnt_q[IDX_W-1:0]] <= digit_full[3:0];
    end
  end

  assign rd_digit_o      = store_q[rd_idx_i];
  assign status_o.done   = byte_valid_i && (state_d == scfp_pkg::PS_DONE);
  assign status_o.opcode = opc_q;

endmodule

// ===== hw/rtl/scfp_calc.sv =====
// ----------------------------------------------------------------------------
// scfp_calc
// Move decode sequencer: one shared 12-bit add/subtract unit for digit
// accumulation and spin magnitude, one shared multiplier for the width
// product and the divide by 500 as a reciprocal multiply.
// ----------------------------------------------------------------------------
module scfp_calc #(
  parameter int unsigned DIGIT_DEPTH = scfp_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [scfp_pkg::PERIOD_W-1:0]     period_i,
  output logic [$clog2(DIGIT_DEPTH)-1:0]    rd_idx_o,
  input  logic [3:0]                        rd_digit_i,
  output scfp_pkg::move_result_t            result_o
);

  localparam int unsigned IDX_W   = $clog2(DIGIT_DEPTH);
  localparam int unsigned ALU_W   = scfp_pkg::ALU_W;
  localparam int unsigned VAL_W   = scfp_pkg::VAL_W;
  localparam int unsigned PROD_W  = scfp_pkg::PROD_W;
  localparam int unsigned MAG_W   = scfp_pkg::MAG_W;
  localparam int unsigned MUL_A_W = scfp_pkg::MUL_A_W;
  localparam int unsigned MUL_B_W = scfp_pkg::MUL_B_W;
  localparam int unsigned MUL_W   = scfp_pkg::MUL_W;

  scfp_pkg::seq_state_e seq_q, seq_d;
  logic [3:0]        idx_q, idx_d;
  logic [1:0]        pos_q, pos_d;
  logic [1:0]        grp_q, grp_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic [VAL_W-1:0]  x_q, x_d, y_q, y_d, s_q, s_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  logic [ALU_W-1:0]   alu_a, alu_b, alu_y;
  logic               alu_sub;
  logic [ALU_W-1:0]   acc_ext, acc_x10;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_y;

  assign acc_ext = {{(ALU_W-VAL_W){acc_q[VAL_W-1]}}, acc_q};
  assign acc_x10 = (acc_ext << 3) + (acc_ext << 1);
  assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign mul_y   = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_comb begin
    seq_d   = seq_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    grp_d   = grp_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    s_d     = s_q;
    mag_d   = mag_q;
    prod_d  = prod_q;
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (seq_q)
      scfp_pkg::SQ_IDLE: begin
        if (start_i) begin
          seq_d = scfp_pkg::SQ_ACC;
          idx_d = '0;
          pos_d = '0;
          grp_d = '0;
        end
      end
      scfp_pkg::SQ_ACC: begin
        alu_a = (pos_q == 2'd0) ? scfp_pkg::MOVE_BIAS_HI : acc_x10;
        alu_b = ALU_W'(rd_digit_i);
        acc_d = alu_y[VAL_W-1:0];
        idx_d = idx_q + 1'b1;
        if (pos_q == 2'd2) begin
          pos_d = '0;
          case (grp_q)
            2'd0:    x_d = alu_y[VAL_W-1:0];
            2'd1:    y_d = alu_y[VAL_W-1:0];
            default: s_d = alu_y[VAL_W-1:0];
          endcase
          if (grp_q == 2'd2) begin
            seq_d = scfp_pkg::SQ_ABS;
          end else begin
            grp_d = grp_q + 1'b1;
          end
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      scfp_pkg::SQ_ABS: begin
        // spin spans -500..499, so |spin| never exceeds 500
        alu_b   = {{(ALU_W-VAL_W){s_q[VAL_W-1]}}, s_q};
        alu_sub = s_q[VAL_W-1];
        mag_d   = alu_y[MAG_W-1:0];
        seq_d   = scfp_pkg::SQ_MUL;
      end
      scfp_pkg::SQ_MUL: begin
        mul_a  = MUL_A_W'(period_i);
        mul_b  = MUL_B_W'(mag_q);
        prod_d = mul_y[PROD_W-1:0];
        seq_d  = scfp_pkg::SQ_DIV;
      end
      scfp_pkg::SQ_DIV: begin
        // prod / 500 = (prod >> 2) / 125, exact for a 23-bit dividend
        mul_a  = prod_q[PROD_W-1:2];
        mul_b  = scfp_pkg::RECIP_125;
        prod_d = PROD_W'(mul_y[scfp_pkg::RECIP_SH +: scfp_pkg::PERIOD_W]);
        seq_d  = scfp_pkg::SQ_DONE;
      end
      default: begin
        seq_d = scfp_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= scfp_pkg::SQ_IDLE;
    end else begin
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    grp_q  <= grp_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    y_q    <= y_d;
    s_q    <= s_d;
    mag_q  <= mag_d;
    prod_q <= prod_d;
  end

  assign rd_idx_o            = IDX_W'(idx_q);
  assign result_o.busy       = (seq_q != scfp_pkg::SQ_IDLE);
  assign result_o.done       = (seq_q == scfp_pkg::SQ_DONE);
  assign result_o.x_move     = x_q;
  assign result_o.y_move     = y_q;
  assign result_o.spin_value = s_q;
  assign result_o.reverse    = s_q[VAL_W-1];
  assign result_o.width      = prod_q[scfp_pkg::PERIOD_W-1:0];

endmodule

// ===== hw/rtl/serial_command_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// serial_command_frame_parser_core
// Output: a timeout or a byte that does not finish a move frame gives its
//   result in the output register in the cycle after acceptance; a byte that
//   finishes a move frame starts a decode of 9 digit steps and 1 abs on the
//   shared adder, 1 multiply and 1 reciprocal multiply on the shared
//   multiplier, and 1 done step, whose result is then registered.
// Throughput: 1 item per cycle while the output drains; input held off
//   during move decode. Reset: parser idle, parser digits and counters and
//   timeout count zero, motor period 1000, timeout_limit 10.
// ----------------------------------------------------------------------------
module serial_command_frame_parser_core #(
  parameter int unsigned DIGIT_DEPTH = scfp_pkg::DIGIT_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // rx_byte
  input  logic                               s_axis_tuser,   // op
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // opcode, x_move, y_move, spin_value, motor_update, motor_reverse,
  // motor_width, failsafe_stop, zero fill
  output logic [63:0]                        m_axis_tdata,
  output logic                               m_axis_tlast,   // frame_done
  input  logic                               cfg_we_i,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [scfp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(DIGIT_DEPTH);

  logic [scfp_pkg::PERIOD_W-1:0] period_q;
  logic [scfp_pkg::LIMIT_W-1:0]  limit_q;
  logic [scfp_pkg::LIMIT_W-1:0]  tcnt_q, tcnt_d, tcnt_inc;
  logic                          out_valid_q, out_valid_d;
  scfp_pkg::result_t             out_q, out_d;

  logic                    in_fire, byte_fire, to_fire, calc_start, load;
  logic                    failsafe;
  logic [IDX_W-1:0]        rd_idx;
  logic [3:0]              rd_digit;
  scfp_pkg::parse_status_t pstat;
  scfp_pkg::move_result_t  mres;

  scfp_parser #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_fire),
    .rx_byte_i    (s_axis_tdata),
    .rd_idx_i     (rd_idx),
    .rd_digit_o   (rd_digit),
    .status_o     (pstat)
  );

  scfp_calc #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (calc_start),
    .period_i     (period_q),
    .rd_idx_o     (rd_idx),
    .rd_digit_i   (rd_digit),
    .result_o     (mres)
  );

  assign s_axis_tready = !mres.busy && (!out_valid_q || m_axis_tready);
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign byte_fire  = in_fire && !s_axis_tuser;
  assign to_fire    = in_fire && s_axis_tuser;
  assign calc_start = byte_fire && pstat.done && (pstat.opcode == scfp_pkg::OPC_MOVE);
  assign load       = (in_fire && !calc_start) || mres.done;

  assign tcnt_inc = tcnt_q + 1'b1;
  assign failsafe = (tcnt_inc == limit_q);

  always_comb begin
    tcnt_d = tcnt_q;
    if (to_fire) begin
      tcnt_d = failsafe ? '0 : tcnt_inc;
    end else if (byte_fire) begin
      tcnt_d = '0;
    end
  end

  always_comb begin
    out_d = '0;
    if (mres.done) begin
      out_d.frame_done    = 1'b1;
      out_d.opcode        = scfp_pkg::OPC_MOVE;
      out_d.x_move        = mres.x_move;
      out_d.y_move        = mres.y_move;
      out_d.spin_value    = mres.spin_value;
      out_d.motor_update  = 1'b1;
      out_d.motor_reverse = mres.reverse;
      out_d.motor_width   = mres.width;
    end else if (to_fire) begin
      out_d.failsafe_stop = failsafe;
    end else begin
      out_d.frame_done = pstat.done;
      out_d.opcode     = pstat.done ? pstat.opcode : '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= scfp_pkg::MOTOR_PERIOD_RST;
      limit_q     <= scfp_pkg::TIMEOUT_LIMIT_RST;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          scfp_pkg::CFG_MOTOR_PERIOD:  period_q <= cfg_data_i;
          scfp_pkg::CFG_TIMEOUT_LIMIT: limit_q  <= cfg_data_i[scfp_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      tcnt_q      <= tcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.frame_done;
  assign m_axis_tdata  = {7'd0, out_q.failsafe_stop, out_q.motor_width, out_q.motor_reverse,
                          out_q.motor_update, out_q.spin_value, out_q.y_move, out_q.x_move,
                          out_q.opcode};

endmodule
